@@ sv/ptta_pkg.sv @@
// Shared types, codes and constants for the turn-to-heading PID block.
`default_nettype none
package ptta_pkg;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 72;
    localparam int ADDR_W     = 5;

    localparam logic signed [31:0] TARGET_RST = 32'sd5898240;
    localparam logic        [30:0] BAND_RST   = 31'd65536;
    localparam logic        [23:0] TLIMIT_RST = 24'd65536;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // divider: 50-bit dividend, two quotient bits per cycle
    localparam int DIV_W     = 50;
    localparam int DIV_ITERS = DIV_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_ITERS);

    typedef enum logic [2:0] {
        CFG_TARGET,
        CFG_BAND,
        CFG_GAIN_P,
        CFG_GAIN_I,
        CFG_GAIN_D,
        CFG_BIAS,
        CFG_TLIMIT
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] target;
        logic        [30:0] band;
        logic signed [31:0] gain_p;
        logic signed [31:0] gain_i;
        logic signed [31:0] gain_d;
        logic signed [31:0] bias;
        logic        [23:0] tlimit;
    } t_cfg;

    typedef enum logic [1:0] {
        GOAL_IDLE,
        GOAL_ACTIVE,
        GOAL_DONE
    } t_goal;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_START,
        OP_EDIV_INIT,
        OP_DIV_STEP,
        OP_ERR,
        OP_MUL_I,
        OP_INTEG,
        OP_DDIV_INIT,
        OP_DERIV,
        OP_MUL_P,
        OP_ACC_P,
        OP_ACC_I,
        OP_ACC_D,
        OP_EMIT
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_EINIT,
        ST_EDIV,
        ST_ERR,
        ST_MULI,
        ST_INTEG,
        ST_DINIT,
        ST_DDIV,
        ST_DERIV,
        ST_MULP,
        ST_ACCP,
        ST_ACCI,
        ST_ACCD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        t_op  op;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_goal goal;
        logic  drive;
    } t_dp_stat;

endpackage
`default_nettype wire

@@ sv/ptta_regs.sv @@
// Configuration register file behind the APB-style port.
`default_nettype none
module ptta_regs import ptta_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg     r_cfg;
    logic     wr_en;
    t_cfg_idx idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = t_cfg_idx'(paddr[ADDR_W-1:2]);
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target <= TARGET_RST;
            r_cfg.band   <= BAND_RST;
            r_cfg.gain_p <= '0;
            r_cfg.gain_i <= '0;
            r_cfg.gain_d <= '0;
            r_cfg.bias   <= '0;
            r_cfg.tlimit <= TLIMIT_RST;
        end else if (wr_en) begin
            unique case (idx)
                CFG_TARGET: r_cfg.target <= pwdata;
                CFG_BAND:   r_cfg.band   <= pwdata[30:0];
                CFG_GAIN_P: r_cfg.gain_p <= pwdata;
                CFG_GAIN_I: r_cfg.gain_i <= pwdata;
                CFG_GAIN_D: r_cfg.gain_d <= pwdata;
                CFG_BIAS:   r_cfg.bias   <= pwdata;
                CFG_TLIMIT: r_cfg.tlimit <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            CFG_TARGET: prdata = r_cfg.target;
            CFG_BAND:   prdata = {1'b0, r_cfg.band};
            CFG_GAIN_P: prdata = r_cfg.gain_p;
            CFG_GAIN_I: prdata = r_cfg.gain_i;
            CFG_GAIN_D: prdata = r_cfg.gain_d;
            CFG_BIAS:   prdata = r_cfg.bias;
            CFG_TLIMIT: prdata = {8'd0, r_cfg.tlimit};
            default:    prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ sv/ptta_dp.sv @@
// Datapath: goal state, shared divider and multiplier, accumulator, result register.
`default_nettype none
module ptta_dp import ptta_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cfg                  i_cfg,
    input  wire t_cmd                  i_cmd,
    input  wire logic [IN_DATA_W-1:0]  i_tdata,
    output t_dp_stat                   o_stat,
    output logic      [OUT_DATA_W-1:0] o_tdata
);

    // goal state
    t_goal              r_status;
    logic [39:0]        r_elapsed;
    logic signed [63:0] r_integ;
    logic signed [31:0] r_prev;

    // per-item working registers
    logic signed [31:0] r_angle;
    logic [23:0]        r_dt;
    logic signed [31:0] r_err;
    logic signed [31:0] r_deriv;
    logic               r_drive;
    logic signed [63:0] r_prod;
    logic signed [50:0] r_acc;
    logic [OUT_DATA_W-1:0] r_out;

    // divider
    logic [31:0]      r_rem;
    logic [31:0]      r_dvs;
    logic [DIV_W-1:0] r_dvd;
    logic             r_dneg;

    logic [32:0]      try1, try2;
    logic             ge1, ge2;
    logic [31:0]      rem1, rem2;
    logic signed [31:0] quo_sat;

    logic signed [32:0] e_diff, d_diff;
    logic [32:0]        e_mag, d_mag;
    logic [31:0]        tgt_mag;

    logic signed [31:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [64:0] mul_p;

    logic signed [63:0] prod_q;
    logic signed [64:0] integ_sum;
    logic signed [63:0] integ_n;
    logic signed [31:0] icl;
    logic signed [50:0] acc_term;

    logic signed [33:0] ang34, lo34, hi34;
    logic               outside;
    logic [40:0]        el_sum;

    logic signed [31:0] left_sat, left_o, right_o;
    logic               timed;

    assign o_stat.goal  = r_status;
    assign o_stat.drive = r_drive;
    assign o_tdata      = r_out;

    // two restoring division steps per cycle
    always_comb begin
        try1 = {r_rem, r_dvd[DIV_W-1]};
        ge1  = try1 >= {1'b0, r_dvs};
        rem1 = ge1 ? 32'(try1 - {1'b0, r_dvs}) : try1[31:0];
        try2 = {rem1, r_dvd[DIV_W-2]};
        ge2  = try2 >= {1'b0, r_dvs};
        rem2 = ge2 ? 32'(try2 - {1'b0, r_dvs}) : try2[31:0];
    end

    // signed quotient from magnitude and sign, saturated to 32 bits
    always_comb begin
        if (r_dneg) begin
            if (r_dvd > DIV_W'(64'h8000_0000)) quo_sat = S32_MIN;
            else                               quo_sat = -$signed(r_dvd[31:0]);
        end else begin
            if (r_dvd > DIV_W'(64'h7FFF_FFFF)) quo_sat = S32_MAX;
            else                               quo_sat = $signed(r_dvd[31:0]);
        end
    end

    always_comb begin
        e_diff  = 33'(i_cfg.target) - 33'(r_angle);
        e_mag   = e_diff[32] ? 33'(-e_diff) : 33'(e_diff);
        d_diff  = 33'(r_err) - 33'(r_prev);
        d_mag   = d_diff[32] ? 33'(-d_diff) : 33'(d_diff);
        tgt_mag = i_cfg.target[31] ? 32'(-i_cfg.target) : 32'(i_cfg.target);
    end

    // shared multiplier operand select
    always_comb begin
        case (i_cmd.op)
            OP_MUL_I: begin mul_a = r_err;        mul_b = $signed({9'd0, r_dt}); end
            OP_MUL_P: begin mul_a = i_cfg.gain_p; mul_b = 33'(r_err);            end
            OP_ACC_P: begin mul_a = i_cfg.gain_i; mul_b = 33'(icl);              end
            OP_ACC_I: begin mul_a = i_cfg.gain_d; mul_b = 33'(r_deriv);          end
            default:  begin mul_a = '0;           mul_b = '0;                    end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb begin
        // floor of the product over 2^16
        prod_q    = 64'($signed(r_prod[63:16]));
        acc_term  = 51'($signed(r_prod[63:16]));
        integ_sum = 65'(r_integ) + 65'(prod_q);
        if (integ_sum[64] != integ_sum[63])
            integ_n = integ_sum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        else
            integ_n = integ_sum[63:0];
        if (r_integ[63:31] == '0 || r_integ[63:31] == '1) icl = r_integ[31:0];
        else icl = r_integ[63] ? S32_MIN : S32_MAX;
    end

    always_comb begin
        ang34   = 34'(r_angle);
        lo34    = 34'(i_cfg.target) - $signed({3'd0, i_cfg.band});
        hi34    = 34'(i_cfg.target) + $signed({3'd0, i_cfg.band});
        outside = (ang34 < lo34) || (ang34 > hi34);
        el_sum  = {1'b0, r_elapsed} + 41'(r_dt);
    end

    always_comb begin
        if (r_acc > 51'(S32_MAX))      left_sat = S32_MAX;
        else if (r_acc < 51'(S32_MIN)) left_sat = S32_MIN;
        else                           left_sat = r_acc[31:0];
        left_o  = r_drive ? left_sat : '0;
        if (!r_drive)                  right_o = '0;
        else if (left_sat == S32_MIN)  right_o = S32_MAX;
        else                           right_o = -left_sat;
        timed = r_elapsed > {16'd0, i_cfg.tlimit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status  <= GOAL_IDLE;
            r_elapsed <= '0;
            r_integ   <= '0;
            r_prev    <= '0;
        end else begin
            case (i_cmd.op)
                OP_START: begin
                    r_status  <= GOAL_ACTIVE;
                    r_elapsed <= '0;
                    r_integ   <= '0;
                    r_prev    <= '0;
                end
                OP_ERR: begin
                    r_elapsed <= el_sum[40] ? '1 : el_sum[39:0];
                    if (!outside) r_status <= GOAL_DONE;
                end
                OP_INTEG:     r_integ <= integ_n;
                OP_DDIV_INIT: r_prev  <= r_err;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_angle <= $signed(i_tdata[31:0]);
                r_dt    <= i_tdata[55:32];
                r_drive <= 1'b0;
            end
            OP_START: r_drive <= 1'b0;
            OP_EDIV_INIT: begin
                r_rem  <= '0;
                r_dvs  <= tgt_mag;
                r_dvd  <= {1'b0, e_mag, 16'd0};
                r_dneg <= e_diff[32] ^ i_cfg.target[31];
            end
            OP_DIV_STEP: begin
                r_rem <= rem2;
                r_dvd <= {r_dvd[DIV_W-3:0], ge1, ge2};
            end
            OP_ERR: begin
                r_err   <= (i_cfg.target == '0) ? '0 : quo_sat;
                r_drive <= outside;
            end
            OP_MUL_I: r_prod <= mul_p[63:0];
            OP_DDIV_INIT: begin
                r_rem  <= '0;
                r_dvs  <= {8'd0, r_dt};
                r_dvd  <= {1'b0, d_mag, 16'd0};
                r_dneg <= d_diff[32];
            end
            OP_DERIV: r_deriv <= (r_dt == '0) ? '0 : quo_sat;
            OP_MUL_P: r_prod  <= mul_p[63:0];
            OP_ACC_P: begin
                r_acc  <= 51'(i_cfg.bias) + acc_term;
                r_prod <= mul_p[63:0];
            end
            OP_ACC_I: begin
                r_acc  <= r_acc + acc_term;
                r_prod <= mul_p[63:0];
            end
            OP_ACC_D: r_acc <= r_acc + acc_term;
            default: ;
        endcase
        if (i_cmd.out_load)
            r_out <= {4'd0, timed, r_status, r_drive, right_o, left_o};
    end

endmodule
`default_nettype wire

@@ sv/ptta_ctrl.sv @@
// Sequencer: handshakes, step order of one tick, divider iteration count.
`default_nettype none
module ptta_ctrl import ptta_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_start,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    input  wire t_dp_stat i_stat,
    output t_cmd          o_cmd
);

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_valid, n_valid;
    logic                 div_last;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_valid;
    assign div_last    = (r_cnt == DIV_CNT_W'(DIV_ITERS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        n_valid        = r_valid & ~i_out_ready;
        o_cmd.op       = OP_NONE;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    if (i_start)                        n_state = ST_START;
                    else if (i_stat.goal != GOAL_ACTIVE) n_state = ST_EMIT;
                    else                                n_state = ST_EINIT;
                end
            end
            ST_START: begin
                o_cmd.op = OP_START;
                n_state  = ST_EMIT;
            end
            ST_EINIT: begin
                o_cmd.op = OP_EDIV_INIT;
                n_cnt    = '0;
                n_state  = ST_EDIV;
            end
            ST_EDIV: begin
                o_cmd.op = OP_DIV_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (div_last) n_state = ST_ERR;
            end
            ST_ERR: begin
                o_cmd.op = OP_ERR;
                n_state  = ST_MULI;
            end
            ST_MULI: begin
                o_cmd.op = OP_MUL_I;
                n_state  = ST_INTEG;
            end
            ST_INTEG: begin
                o_cmd.op = OP_INTEG;
                n_state  = ST_DINIT;
            end
            ST_DINIT: begin
                o_cmd.op = OP_DDIV_INIT;
                n_cnt    = '0;
                n_state  = ST_DDIV;
            end
            ST_DDIV: begin
                o_cmd.op = OP_DIV_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (div_last) n_state = ST_DERIV;
            end
            ST_DERIV: begin
                o_cmd.op = OP_DERIV;
                n_state  = ST_MULP;
            end
            ST_MULP: begin
                o_cmd.op = OP_MUL_P;
                n_state  = ST_ACCP;
            end
            ST_ACCP: begin
                o_cmd.op = OP_ACC_P;
                n_state  = ST_ACCI;
            end
            ST_ACCI: begin
                o_cmd.op = OP_ACC_I;
                n_state  = ST_ACCD;
            end
            ST_ACCD: begin
                o_cmd.op = OP_ACC_D;
                n_state  = ST_EMIT;
            end
            ST_EMIT: begin
                // hold until the output register is free
                if (!r_valid || i_out_ready) begin
                    o_cmd.op       = OP_EMIT;
                    o_cmd.out_load = 1'b1;
                    n_valid        = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

@@ sv/pid_turn_to_angle.sv @@
// Turn-to-heading PID goal with completion band: top level.
//
// Input stream (s_*): one beat per item. s_tuser is the request kind
// (0 control tick, 1 start goal); s_tdata holds heading and step_time.
// Output stream (m_*): exactly one result beat per input beat, in order.
// Configuration: APB-style writes to seven registers at byte address 4*i.
//
// Timing: the block works on one item at a time. A start beat passes through
// the start and emit states before the next beat is taken; a tick while the
// goal is idle or completed goes from the idle state straight to emit.
// A tick on an active goal runs the shared two-bit-per-cycle divider twice
// (error, then derivative) plus the shared multiplier passes for the integral
// and the three gain products.
// The result sits in an output register; a new beat is taken while it waits.
// If the receiver stalls, the next result waits in the sequencer until the
// register frees. Reset clears the goal to idle, the stored time, integral
// and previous error, and loads the register defaults.
`default_nettype none
module pid_turn_to_angle import ptta_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // heading[31:0], step_time[55:32]
    input  wire logic                  s_tuser,   // req_type
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // left_power[31:0], right_power[63:32], drive_on[64], goal_state[66:65],
    // timed_out[67], zero fill[71:68]
    output logic      [OUT_DATA_W-1:0] m_tdata,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready
);

    t_cfg     cfg;
    t_cmd     cmd;
    t_dp_stat stat;

    ptta_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ptta_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_tvalid),
        .i_start     (s_tuser),
        .o_in_ready  (s_tready),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ptta_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_cmd   (cmd),
        .i_tdata (s_tdata),
        .o_stat  (stat),
        .o_tdata (m_tdata)
    );

endmodule
`default_nettype wire
